[rtl/core/nkdt_pkg.sv]
`default_nettype none

package nkdt_pkg;

    // Table geometry
    localparam int ENTRIES     = 16;
    localparam int NAME_CHARS  = 8;
    localparam int SECTOR_BITS = 10;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int NAME_W = 8 * NAME_CHARS;

    // Port field widths
    localparam int OP_W       = 2;
    localparam int KEY_W      = 64;
    localparam int IN_SEC_W   = 10;
    localparam int STATUS_W   = 2;
    localparam int OUT_IDX_W  = 4;
    localparam int OUT_SEC_W  = 10;

    // Request kinds
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    // Controller to entry store
    typedef struct packed {
        logic                   rd_en;
        logic [IDX_W-1:0]       rd_addr;
        logic                   wr_en;
        logic                   clr_en;
        logic [IDX_W-1:0]       wr_addr;
        logic [NAME_W-1:0]      wr_name;
        logic [SECTOR_BITS-1:0] wr_sector;
    } mem_req_t;

    // Entry store read data, valid in the cycle after rd_en
    typedef struct packed {
        logic                   valid;
        logic [NAME_W-1:0]      name;
        logic [SECTOR_BITS-1:0] sector;
    } mem_rsp_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [OUT_IDX_W-1:0] index;
        logic [OUT_SEC_W-1:0] sector;
    } res_t;

endpackage

`default_nettype wire

[rtl/core/nkdt_req_if.sv]
`default_nettype none

interface nkdt_req_if import nkdt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [KEY_W-1:0]    name_key;
    logic [IN_SEC_W-1:0] new_sector;

    modport source (output valid, output operation, output name_key, output new_sector,
                    input ready);
    modport sink   (input valid, input operation, input name_key, input new_sector,
                    output ready);
endinterface

`default_nettype wire

[rtl/core/nkdt_rsp_if.sv]
`default_nettype none

interface nkdt_rsp_if import nkdt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [OUT_IDX_W-1:0] entry_index;
    logic [OUT_SEC_W-1:0] entry_sector;

    modport source (output valid, output status, output entry_index, output entry_sector,
                    input ready);
    modport sink   (input valid, input status, input entry_index, input entry_sector,
                    output ready);
endinterface

`default_nettype wire

[rtl/core/nkdt_entry_store.sv]
`default_nettype none

module nkdt_entry_store import nkdt_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mem_req_t mem_req,
    output mem_rsp_t      mem_rsp
);

    typedef struct packed {
        logic [NAME_W-1:0]      name;
        logic [SECTOR_BITS-1:0] sector;
    } entry_t;

    entry_t                 mem_array [ENTRIES];
    entry_t                 rd_entry_reg;
    logic [ENTRIES-1:0]     valid_reg;
    logic                   rd_valid_reg;

    // name and sector memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem_array[mem_req.wr_addr] <= '{name: mem_req.wr_name, sector: mem_req.wr_sector};
        end
        if (mem_req.rd_en)
        begin
            rd_entry_reg <= mem_array[mem_req.rd_addr];
        end
    end

    // valid marks live in flops so that reset clears them at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_req.wr_en)
            begin
                valid_reg[mem_req.wr_addr] <= 1'b1;
            end
            else if (mem_req.clr_en)
            begin
                valid_reg[mem_req.wr_addr] <= 1'b0;
            end
            if (mem_req.rd_en)
            begin
                rd_valid_reg <= valid_reg[mem_req.rd_addr];
            end
        end
    end

    assign mem_rsp.valid  = rd_valid_reg;
    assign mem_rsp.name   = rd_entry_reg.name;
    assign mem_rsp.sector = rd_entry_reg.sector;

endmodule

`default_nettype wire

[rtl/core/nkdt_ctrl.sv]
`default_nettype none

module nkdt_ctrl import nkdt_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire logic [OP_W-1:0]     req_op,
    input  wire logic [KEY_W-1:0]    req_key,
    input  wire logic [IN_SEC_W-1:0] req_sector,
    input  wire logic                res_free,
    output logic                     done,
    output res_t                     res,
    output mem_req_t                 mem_req,
    input  wire mem_rsp_t            mem_rsp
);

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   cmp_valid_reg;
    logic [IDX_W-1:0]       cmp_idx_reg;
    logic [OP_W-1:0]        op_reg;
    logic [NAME_W-1:0]      key_reg;
    logic [SECTOR_BITS-1:0] sec_reg;
    logic                   hit_found_reg;
    logic [IDX_W-1:0]       hit_idx_reg;
    logic [SECTOR_BITS-1:0] hit_sec_reg;
    logic                   free_found_reg;
    logic [IDX_W-1:0]       free_idx_reg;
    logic                   accept;
    logic                   scan_done;
    logic                   name_hit;

    assign accept    = req_valid && req_ready;
    assign scan_done = (cnt_reg == CNT_W'(ENTRIES)) && !cmp_valid_reg;
    assign name_hit  = mem_rsp.valid && (mem_rsp.name == key_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (req_valid) state_next = S_SCAN;
            S_SCAN:   if (scan_done) state_next = S_FINISH;
            S_FINISH: if (res_free)  state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready         = (state_reg == S_IDLE);
        done              = (state_reg == S_FINISH) && res_free;
        mem_req.rd_en     = (state_reg == S_SCAN) && (cnt_reg < CNT_W'(ENTRIES));
        mem_req.rd_addr   = cnt_reg[IDX_W-1:0];
        mem_req.wr_en     = 1'b0;
        mem_req.clr_en    = 1'b0;
        mem_req.wr_addr   = hit_idx_reg;
        mem_req.wr_name   = key_reg;
        mem_req.wr_sector = sec_reg;
        res.status        = STAT_NOT_FOUND;
        res.index         = '0;
        res.sector        = '0;
        unique case (op_reg)
            OP_LOOKUP:
            begin
                if (hit_found_reg)
                begin
                    res.status = STAT_OK;
                    res.index  = OUT_IDX_W'(hit_idx_reg);
                    res.sector = OUT_SEC_W'(hit_sec_reg);
                end
            end
            OP_ADD:
            begin
                if (hit_found_reg)
                begin
                    res.status = STAT_DUPLICATE;
                    res.index  = OUT_IDX_W'(hit_idx_reg);
                end
                else if (free_found_reg)
                begin
                    res.status      = STAT_OK;
                    res.index       = OUT_IDX_W'(free_idx_reg);
                    mem_req.wr_addr = free_idx_reg;
                    mem_req.wr_en   = done;
                end
                else
                begin
                    res.status = STAT_FULL;
                end
            end
            OP_REMOVE:
            begin
                if (hit_found_reg)
                begin
                    res.status     = STAT_OK;
                    res.index      = OUT_IDX_W'(hit_idx_reg);
                    mem_req.clr_en = done;
                end
            end
            default:
            begin
                res.status = STAT_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            cmp_valid_reg  <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg        <= '0;
                cmp_valid_reg  <= 1'b0;
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                cmp_valid_reg <= mem_req.rd_en;
                if (mem_req.rd_en)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                // first valid match and first free slot, lowest index wins
                if (cmp_valid_reg && name_hit && !hit_found_reg)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (cmp_valid_reg && !mem_rsp.valid && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req_op;
            key_reg <= NAME_W'(req_key);
            sec_reg <= SECTOR_BITS'(req_sector);
        end
        cmp_idx_reg <= mem_req.rd_addr;
        if (cmp_valid_reg && name_hit && !hit_found_reg)
        begin
            hit_idx_reg <= cmp_idx_reg;
            hit_sec_reg <= mem_rsp.sector;
        end
        if (cmp_valid_reg && !mem_rsp.valid && !free_found_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
    end

    // reads and write-back never share a cycle, so no forwarding is needed
    a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.rd_en && (mem_req.wr_en || mem_req.clr_en)))
        else $error("entry store read and write in the same cycle");

    a_done_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> res_free)
        else $error("result issued while output register occupied");

    a_write_only_on_add: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> (op_reg == OP_ADD) && !hit_found_reg && free_found_reg)
        else $error("entry written outside a successful add");

    a_clear_only_on_remove: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.clr_en |-> (op_reg == OP_REMOVE) && hit_found_reg)
        else $error("valid mark cleared outside a successful remove");

    a_scan_starts_clean: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !hit_found_reg && !free_found_reg && (cnt_reg == '0))
        else $error("scan state not cleared on a new request");

endmodule

`default_nettype wire

[rtl/core/name_keyed_directory_table.sv]
`default_nettype none

// Channel | Modport | Payload                                 | Role
// req     | sink    | operation, name_key, new_sector         | lookup / add / remove
// rsp     | source  | status, entry_index, entry_sector       | one result per request
//
// A request scans every entry between its accept and its result appearing, limited
// by the single read port of the entry memory: one entry is read per cycle.
// A new request is taken the cycle after the result is loaded, even while it waits.
// Reset clears the valid marks, the sequencer and the output register at once.
// A stalled rsp holds its result; the finished request waits until the register frees.
module name_keyed_directory_table import nkdt_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    nkdt_req_if.sink    req,
    nkdt_rsp_if.source  rsp
);

    mem_req_t mem_req;
    mem_rsp_t mem_rsp;
    res_t     res;
    res_t     res_reg;
    logic     out_valid_reg;
    logic     res_free;
    logic     done;

    // the output register frees when empty or when its transaction completes
    assign res_free = !out_valid_reg || rsp.ready;

    nkdt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_ready  (req.ready),
        .req_op     (req.operation),
        .req_key    (req.name_key),
        .req_sector (req.new_sector),
        .res_free   (res_free),
        .done       (done),
        .res        (res),
        .mem_req    (mem_req),
        .mem_rsp    (mem_rsp)
    );

    nkdt_entry_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .mem_req (mem_req),
        .mem_rsp (mem_rsp)
    );

    // hold the result until taken, load the next one as this one leaves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            res_reg <= res;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = res_reg.status;
    assign rsp.entry_index  = res_reg.index;
    assign rsp.entry_sector = res_reg.sector;

endmodule

`default_nettype wire
